FILE: rtl/dcti_pkg.sv
`timescale 1ns / 1ps

package dcti_pkg;

    // time constants
    localparam int unsigned DAY_SECONDS  = 3600 * 24;
    localparam int unsigned HOUR_SECONDS = 3600;
    localparam int unsigned LEVEL_MAX    = 100;

    // seconds of day: 86400 = 2^7 * 675, so the mod splits into a shift and a mod 675
    localparam int unsigned DAY_SHIFT       = 7;
    localparam int unsigned DAY_ODD         = DAY_SECONDS >> DAY_SHIFT;
    localparam int unsigned DAY_RECIP_SHIFT = 35;
    localparam logic [25:0] DAY_RECIP       = 26'((64'd1 << DAY_RECIP_SHIFT) / 64'(DAY_ODD));

    // field widths
    localparam int unsigned SECS_W  = 32;
    localparam int unsigned TIME_W  = 17;
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned ZONE_W  = 5;
    localparam int unsigned NOW_W   = 19;
    localparam int unsigned NUM_W   = 24;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_C  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_C = 3'd7;

    // pipeline layout
    localparam int unsigned DIV_STEPS  = 7;
    localparam int unsigned STG_PROD   = 0;
    localparam int unsigned STG_REM    = 1;
    localparam int unsigned STG_NOW    = 2;
    localparam int unsigned STG_SEL    = 3;
    localparam int unsigned STG_MUL    = 4;
    localparam int unsigned STG_OUT    = STG_MUL + DIV_STEPS + 1;
    localparam int unsigned NUM_STAGES = STG_OUT + 1;

    // beat payloads
    typedef struct packed {
        logic [SECS_W-1:0] unix_seconds;
    } t_in_beat;

    typedef struct packed {
        logic               active;
        logic [LEVEL_W-1:0] temp_level;
    } t_out_beat;

endpackage

FILE: rtl/dcti_in_if.sv
`timescale 1ns / 1ps

interface dcti_in_if;
    import dcti_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/dcti_out_if.sv
`timescale 1ns / 1ps

interface dcti_out_if;
    import dcti_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/daily_colour_temp_interpolator_core.sv
`timescale 1ns / 1ps

// Daily colour temperature schedule: maps a UTC time in seconds to a level 0..100
// through three breakpoints (time, level), interpolating between them.
// Channels: i_req carries one unix_seconds beat, o_rsp returns one beat
// (active, temp_level) per request beat, in order. Both use valid/ready.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (enable, zone offset,
// three breakpoint times, three levels); write only while the pipe is empty.
// Pipeline: 13 register stages.
// Throughput: one beat per cycle while o_rsp is ready; the seconds-of-day
// reduction, the interpolation multiply and a 7-step restoring divider (one
// quotient bit per stage) are all pipelined, so no unit is shared between beats.
// Each stage holds its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles fill even while o_rsp is stalled; a full
// stalled pipe holds every beat and drops i_req.ready.
// Reset (synchronous, active low) clears all valid bits and sets every
// configuration register to zero, so the block starts disabled.
module daily_colour_temp_interpolator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dcti_in_if.sink                       i_req,
    dcti_out_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [dcti_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dcti_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dcti_pkg::*;

    // configuration registers
    logic               r_enable;
    logic [ZONE_W-1:0]  r_zone;
    logic [TIME_W-1:0]  r_time_a, r_time_b, r_time_c;
    logic [LEVEL_W-1:0] r_level_a, r_level_b, r_level_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_zone    <= '0;
            r_time_a  <= '0;
            r_time_b  <= '0;
            r_time_c  <= '0;
            r_level_a <= '0;
            r_level_b <= '0;
            r_level_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                CFG_ZONE:    r_zone    <= i_cfg_data[ZONE_W-1:0];
                CFG_TIME_A:  r_time_a  <= i_cfg_data[TIME_W-1:0];
                CFG_TIME_B:  r_time_b  <= i_cfg_data[TIME_W-1:0];
                CFG_TIME_C:  r_time_c  <= i_cfg_data[TIME_W-1:0];
                CFG_LEVEL_A: r_level_a <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_B: r_level_b <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_C: r_level_c <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // per-stage valid bits and load enables
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_ce;

    always_comb begin
        w_ce[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_rsp.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ce[k] = !r_vld[k] || w_ce[k+1];
        end
    end

    assign i_req.ready = w_ce[STG_PROD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_ce[k]) begin
                    r_vld[k] <= (k == 0) ? i_req.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // stage 0: reciprocal product for the mod 675 of seconds >> 7
    logic [50:0] w_prod;
    logic [50:0] r_s0_prod;
    logic [24:0] r_s0_y;
    logic [6:0]  r_s0_lo;

    assign w_prod = {26'b0, i_req.payload.unix_seconds[SECS_W-1:DAY_SHIFT]} * {25'b0, DAY_RECIP};

    always_ff @(posedge i_clk) begin
        if (w_ce[STG_PROD]) begin
            r_s0_prod <= w_prod;
            r_s0_y    <= i_req.payload.unix_seconds[SECS_W-1:DAY_SHIFT];
            r_s0_lo   <= i_req.payload.unix_seconds[DAY_SHIFT-1:0];
        end
    end

    // stage 1: quotient estimate is exact or one low, remainder below twice 675
    logic [15:0] w_qest;
    logic [25:0] w_qmul;
    logic [25:0] w_rdiff;
    logic [10:0] r_s1_rem;
    logic [6:0]  r_s1_lo;

    assign w_qest  = r_s0_prod[50:DAY_RECIP_SHIFT];
    assign w_qmul  = {10'b0, w_qest} * 26'(DAY_ODD);
    assign w_rdiff = {1'b0, r_s0_y} - w_qmul;

    always_ff @(posedge i_clk) begin
        if (w_ce[STG_REM]) begin
            r_s1_rem <= w_rdiff[10:0];
            r_s1_lo  <= r_s0_lo;
        end
    end

    // stage 2: final correction, seconds of day plus zone offset (no wrap)
    logic [9:0]        w_rem;
    logic [TIME_W-1:0] w_tod;
    logic [NOW_W-1:0]  w_zone_secs;
    logic [NOW_W-1:0]  r_s2_now;

    assign w_rem       = (r_s1_rem >= 11'(DAY_ODD)) ? 10'(r_s1_rem - 11'(DAY_ODD))
                                                    : r_s1_rem[9:0];
    assign w_tod       = {w_rem, r_s1_lo};
    assign w_zone_secs = {{(NOW_W-ZONE_W){r_zone[ZONE_W-1]}}, r_zone} * NOW_W'(HOUR_SECONDS);

    always_ff @(posedge i_clk) begin
        if (w_ce[STG_NOW]) begin
            r_s2_now <= {2'b00, w_tod} + w_zone_secs;
        end
    end

    // stage 3: pick the segment, its origin, span and level step
    logic signed [NOW_W-1:0] w_now, w_ta, w_tb, w_tc;
    logic                    w_seg1, w_seg2;
    logic [NOW_W-1:0]        w_t0;
    logic [TIME_W-1:0]       w_den;
    logic [LEVEL_W-1:0]      w_l0, w_l1;
    logic                    w_interp;
    logic [NOW_W-1:0]        w_dx;
    logic [LEVEL_W:0]        w_dl;
    logic [LEVEL_W:0]        w_dl_abs;
    logic [TIME_W-1:0]       r_s3_dx;
    logic [TIME_W-1:0]       r_s3_den;
    logic [LEVEL_W-1:0]      r_s3_l0;
    logic [LEVEL_W-1:0]      r_s3_mag;
    logic                    r_s3_neg;

    assign w_now  = $signed(r_s2_now);
    assign w_ta   = $signed({2'b00, r_time_a});
    assign w_tb   = $signed({2'b00, r_time_b});
    assign w_tc   = $signed({2'b00, r_time_c});
    assign w_seg1 = (w_now >= w_ta) && (w_now < w_tb);
    assign w_seg2 = (w_now >= w_tb) && (w_now <= w_tc);

    always_comb begin
        // outside an interpolated span the step is zero and l0 carries the level
        w_t0     = r_s2_now;
        w_den    = TIME_W'(1);
        w_l0     = r_level_c;
        w_l1     = r_level_c;
        w_interp = 1'b0;
        if (w_seg1) begin
            w_t0     = {2'b00, r_time_a};
            w_den    = r_time_b - r_time_a;
            w_l0     = r_level_a;
            w_l1     = r_level_b;
            w_interp = 1'b1;
        end else if (w_seg2 && (r_time_c > r_time_b)) begin
            w_t0     = {2'b00, r_time_b};
            w_den    = r_time_c - r_time_b;
            w_l0     = r_level_b;
            w_l1     = r_level_c;
            w_interp = 1'b1;
        end else if (w_seg2) begin
            // zero-length second segment hit exactly at its start
            w_l0 = r_level_b;
            w_l1 = r_level_b;
        end
    end

    assign w_dx     = r_s2_now - w_t0;
    assign w_dl     = {1'b0, w_l1} - {1'b0, w_l0};
    assign w_dl_abs = w_dl[LEVEL_W] ? (~w_dl + 1'b1) : w_dl;

    always_ff @(posedge i_clk) begin
        if (w_ce[STG_SEL]) begin
            r_s3_dx  <= w_interp ? w_dx[TIME_W-1:0] : '0;
            r_s3_den <= w_den;
            r_s3_l0  <= w_l0;
            r_s3_mag <= w_dl_abs[LEVEL_W-1:0];
            r_s3_neg <= w_dl[LEVEL_W];
        end
    end

    // stage 4: numerator magnitude |dl| * dx, enters the divider
    logic [NUM_W-1:0]   r_dv_rem [0:DIV_STEPS];
    logic [TIME_W-1:0]  r_dv_den [0:DIV_STEPS];
    logic [LEVEL_W-1:0] r_dv_q   [0:DIV_STEPS];
    logic [LEVEL_W-1:0] r_dv_l0  [0:DIV_STEPS];
    logic               r_dv_neg [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_ce[STG_MUL]) begin
            r_dv_rem[0] <= {17'b0, r_s3_mag} * {7'b0, r_s3_dx};
            r_dv_den[0] <= r_s3_den;
            r_dv_q[0]   <= '0;
            r_dv_l0[0]  <= r_s3_l0;
            r_dv_neg[0] <= r_s3_neg;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int unsigned BIT = DIV_STEPS - 1 - k;
        logic [NUM_W-1:0]   w_den_sh;
        logic               w_ge;
        logic [NUM_W-1:0]   n_rem;
        logic [LEVEL_W-1:0] n_q;

        always_comb begin
            w_den_sh = NUM_W'(r_dv_den[k]) << BIT;
            w_ge     = r_dv_rem[k] >= w_den_sh;
            n_rem    = w_ge ? (r_dv_rem[k] - w_den_sh) : r_dv_rem[k];
            n_q      = r_dv_q[k];
            n_q[BIT] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (w_ce[STG_MUL + 1 + k]) begin
                r_dv_rem[k+1] <= n_rem;
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_q[k+1]   <= n_q;
                r_dv_l0[k+1]  <= r_dv_l0[k];
                r_dv_neg[k+1] <= r_dv_neg[k];
            end
        end
    end

    // output stage: floor for a negative step, add base level, clamp, zero the level when disabled
    logic signed [8:0]  w_qs;
    logic signed [9:0]  w_lvl;
    logic [LEVEL_W-1:0] w_clamped;
    logic               r_out_active;
    logic [LEVEL_W-1:0] r_out_level;

    always_comb begin
        if (r_dv_neg[DIV_STEPS]) begin
            w_qs = -$signed({2'b00, r_dv_q[DIV_STEPS]})
                   - $signed({8'b0, (r_dv_rem[DIV_STEPS] != '0)});
        end else begin
            w_qs = $signed({2'b00, r_dv_q[DIV_STEPS]});
        end
        w_lvl = $signed({3'b000, r_dv_l0[DIV_STEPS]}) + 10'(w_qs);
        if (w_lvl < 0) begin
            w_clamped = '0;
        end else if (w_lvl > $signed(10'(LEVEL_MAX))) begin
            w_clamped = LEVEL_W'(LEVEL_MAX);
        end else begin
            w_clamped = w_lvl[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce[STG_OUT]) begin
            r_out_active <= r_enable;
            r_out_level  <= r_enable ? w_clamped : '0;
        end
    end

    assign o_rsp.valid              = r_vld[STG_OUT];
    assign o_rsp.payload.active     = r_out_active;
    assign o_rsp.payload.temp_level = r_out_level;

    // checks
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.payload.temp_level <= LEVEL_W'(LEVEL_MAX)))
        else $error("level above maximum");

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.payload.active) |-> (o_rsp.payload.temp_level == '0))
        else $error("inactive beat with nonzero level");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STG_OUT-1] |-> (r_dv_rem[DIV_STEPS] < NUM_W'(r_dv_den[DIV_STEPS])))
        else $error("divider remainder not below divisor");

    a_take_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[STG_PROD])
        else $error("accepted beat not captured");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dcti_pkg::*;

    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     DRAIN_CYCLES  = 20;
    localparam int     LONG_HOLD     = 300;
    localparam int     HOLD_AFTER    = 400;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_BEATS   = 137;
    localparam int     DAY_S         = 86400;
    localparam int     LAST_SECOND   = 86399;
    localparam longint SEC_PER_HOUR  = 3600;
    localparam longint LVL_TOP       = 100;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_EVERY_THIRD
    } t_rx_mode;

    // shadow copy of the schedule registers
    typedef struct packed {
        logic               enable;
        logic [ZONE_W-1:0]  zone;
        logic [TIME_W-1:0]  t_a;
        logic [TIME_W-1:0]  t_b;
        logic [TIME_W-1:0]  t_c;
        logic [LEVEL_W-1:0] l_a;
        logic [LEVEL_W-1:0] l_b;
        logic [LEVEL_W-1:0] l_c;
    } t_schedule;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    dcti_in_if  req_if ();
    dcti_out_if rsp_if ();

    t_schedule          sched = '0;
    logic [SECS_W-1:0]  pending_secs[$];
    t_out_beat          expected_levels[$];

    logic [SECS_W-1:0]  sent_secs;
    t_out_beat          want;
    t_rx_mode           stall_mode;
    int                 burst_left;
    int                 gap_left;
    int                 hold_left;
    int                 mode_cycles;
    bit                 long_hold_done;
    int                 beats_sent;
    int                 results_checked;
    int                 input_stall_cycles;
    int                 settings_used;
    int                 error_count;
    int                 cycle_count;

    daily_colour_temp_interpolator_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // l0 + (l1 - l0) * (x - t0) / (t1 - t0), rounded toward minus infinity
    function automatic longint ramp(input longint t0, input longint t1, input longint l0,
                                    input longint l1, input longint x);
        longint prod;
        longint span;
        longint quo;
        prod = (l1 - l0) * (x - t0);
        span = t1 - t0;
        quo  = prod / span;
        // division truncates toward zero, so an inexact negative quotient is one too high
        if (quo * span > prod) quo = quo - 1;
        return l0 + quo;
    endfunction

    // level for one time beat under a given schedule
    function automatic t_out_beat predict_level(input t_schedule s, input logic [SECS_W-1:0] secs);
        t_out_beat res;
        longint    local_t;
        longint    ta;
        longint    tb;
        longint    tc;
        longint    la;
        longint    lb;
        longint    lc;
        longint    lvl;
        res = '0;
        if (s.enable) begin
            // local time of day, not wrapped into a day
            local_t = longint'(secs % DAY_SECONDS) + longint'($signed(s.zone)) * SEC_PER_HOUR;
            ta = s.t_a;
            tb = s.t_b;
            tc = s.t_c;
            la = s.l_a;
            lb = s.l_b;
            lc = s.l_c;
            if (local_t >= ta && local_t < tb) begin
                lvl = ramp(ta, tb, la, lb, local_t);
            end else if (local_t >= tb && local_t <= tc) begin
                lvl = (tc > tb) ? ramp(tb, tc, lb, lc, local_t) : lb;
            end else begin
                lvl = lc;
            end
            if (lvl < 0) lvl = 0;
            if (lvl > LVL_TOP) lvl = LVL_TOP;
            res.active     = 1'b1;
            res.temp_level = LEVEL_W'(lvl);
        end
        return res;
    endfunction

    function automatic t_schedule make_schedule(input logic en, input int zone, input int ta,
                                                input int tb, input int tc, input int la,
                                                input int lb, input int lc);
        t_schedule s;
        s.enable = en;
        s.zone   = ZONE_W'(zone);
        s.t_a    = TIME_W'(ta);
        s.t_b    = TIME_W'(tb);
        s.t_c    = TIME_W'(tc);
        s.l_a    = LEVEL_W'(la);
        s.l_b    = LEVEL_W'(lb);
        s.l_c    = LEVEL_W'(lc);
        return s;
    endfunction

    // random schedule: mostly ordered breakpoints, sometimes degenerate or out of range
    function automatic t_schedule pick_schedule();
        t_schedule   s;
        int unsigned shape;
        s.enable = ($urandom_range(0, 5) != 0);
        s.zone   = ($urandom_range(0, 5) == 0) ? ZONE_W'($urandom)
                                               : ZONE_W'(int'($urandom_range(0, 26)) - 12);
        s.t_a    = TIME_W'($urandom_range(0, 60000));
        s.t_b    = s.t_a + TIME_W'($urandom_range(0, LAST_SECOND - s.t_a));
        s.t_c    = s.t_b + TIME_W'($urandom_range(0, LAST_SECOND - s.t_b));
        shape    = $urandom_range(0, 7);
        case (shape)
            0: s.t_c = s.t_b;
            1: begin
                s.t_a = TIME_W'($urandom);
                s.t_b = TIME_W'($urandom);
                s.t_c = TIME_W'($urandom);
            end
            2: s.t_b = s.t_a;
            default: ;
        endcase
        s.l_a = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(0, 100));
        s.l_b = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(0, 100));
        s.l_c = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(0, 100));
        return s;
    endfunction

    // utc seconds on a random day at a given second of day
    function automatic logic [SECS_W-1:0] unix_at(input int tod);
        return SECS_W'($urandom_range(0, 49709)) * DAY_SECONDS + SECS_W'(tod);
    endfunction

    // wait until every beat is through, then let the pipe run empty
    task automatic settle();
        while (pending_secs.size() != 0 || expected_levels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    task automatic load_schedule(input t_schedule s);
        settle();
        cfg_write(CFG_ENABLE, CFG_DATA_W'(s.enable));
        cfg_write(CFG_ZONE, CFG_DATA_W'($signed(s.zone)));
        cfg_write(CFG_TIME_A, CFG_DATA_W'(s.t_a));
        cfg_write(CFG_TIME_B, CFG_DATA_W'(s.t_b));
        cfg_write(CFG_TIME_C, CFG_DATA_W'(s.t_c));
        cfg_write(CFG_LEVEL_A, CFG_DATA_W'(s.l_a));
        cfg_write(CFG_LEVEL_B, CFG_DATA_W'(s.l_b));
        cfg_write(CFG_LEVEL_C, CFG_DATA_W'(s.l_c));
        @(posedge clk);
        cfg_we <= 1'b0;
        sched = s;
        settings_used++;
    endtask

    // random beats, most of them landing close to a breakpoint in local time
    task automatic queue_random_beats(input int count);
        int target;
        int delta;
        int tod;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 2) begin
                pending_secs.push_back($urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0: target = sched.t_a;
                    1: target = sched.t_b;
                    2: target = sched.t_c;
                    default: target = $urandom_range(0, LAST_SECOND);
                endcase
                delta = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2000)) - 1000
                                                    : int'($urandom_range(0, 8)) - 4;
                tod = target - $signed(sched.zone) * 3600 + delta;
                tod = ((tod % DAY_S) + DAY_S) % DAY_S;
                pending_secs.push_back(unix_at(tod));
            end
        end
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stimulus sequence
    initial begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_ENABLE;
        cfg_data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // straight out of reset the block is disabled
        pending_secs.push_back('0);
        pending_secs.push_back('1);

        // plain rising then falling day, zone at utc
        load_schedule(make_schedule(1'b1, 0, 21600, 43200, 72000, 10, 90, 40));
        pending_secs.push_back(unix_at(21599));
        pending_secs.push_back(unix_at(21600));
        pending_secs.push_back(unix_at(32400));
        pending_secs.push_back(unix_at(43199));
        pending_secs.push_back(unix_at(43200));
        pending_secs.push_back(unix_at(57600));
        pending_secs.push_back(unix_at(72000));
        pending_secs.push_back(unix_at(72001));
        pending_secs.push_back(unix_at(LAST_SECOND));
        pending_secs.push_back('1);

        // second segment of zero length, falling ramp, largest regular zone
        load_schedule(make_schedule(1'b1, 14, 3600, 60000, 60000, 100, 0, 70));
        pending_secs.push_back(unix_at(9600));
        pending_secs.push_back(unix_at(9599));
        pending_secs.push_back(unix_at(LAST_SECOND));
        pending_secs.push_back(unix_at(0));

        // breakpoints out of order, levels above range, negative local time
        load_schedule(make_schedule(1'b1, -12, 50000, 20000, 80000, 127, 127, 127));
        pending_secs.push_back(unix_at(0));
        pending_secs.push_back(unix_at(LAST_SECOND));

        // widest zone and breakpoint times
        load_schedule(make_schedule(1'b1, 15, 0, 131071, 131071, 0, 127, 5));
        pending_secs.push_back(unix_at(LAST_SECOND));
        pending_secs.push_back(unix_at(77071));
        pending_secs.push_back(unix_at(0));

        load_schedule(make_schedule(1'b1, -16, 0, LAST_SECOND, LAST_SECOND, 100, 0, 0));
        pending_secs.push_back(unix_at(0));
        pending_secs.push_back(unix_at(LAST_SECOND));

        // random schedules with random beats
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_schedule(pick_schedule());
            queue_random_beats(PHASE_BEATS);
        end

        settle();
        $display("checked %0d level beats of %0d sent over %0d register settings",
                 results_checked, beats_sent, settings_used);
        $display("input back-pressure seen for %0d cycles, one output hold of %0d cycles",
                 input_stall_cycles, LONG_HOLD);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // time beat driver: bursts of random length with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // accepted beat: predict its level under the current registers
            if (req_if.valid && req_if.ready) begin
                sent_secs = pending_secs.pop_front();
                expected_levels.push_back(predict_level(sched, sent_secs));
                beats_sent++;
            end else if (req_if.valid) begin
                input_stall_cycles++;
            end
            // offer the next beat unless one is still waiting
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0 || pending_secs.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    req_if.valid <= 1'b0;
                end else begin
                    req_if.valid                <= 1'b1;
                    req_if.payload.unix_seconds <= pending_secs[0];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // level beat monitor and receiver stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_mode  = RX_OPEN;
            mode_cycles = 0;
            hold_left   = 0;
        end else begin
            // compare against the oldest prediction
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_levels.size() == 0) begin
                    $error("level beat with none expected: active %0d temp_level %0d",
                           rsp_if.payload.active, rsp_if.payload.temp_level);
                    error_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (rsp_if.payload.active !== want.active) begin
                        $error("active: expected %0d, got %0d",
                               want.active, rsp_if.payload.active);
                        error_count++;
                    end
                    if (rsp_if.payload.temp_level !== want.temp_level) begin
                        $error("temp_level: expected %0d, got %0d",
                               want.temp_level, rsp_if.payload.temp_level);
                        error_count++;
                    end
                    results_checked++;
                end
            end
            // stall pattern is redrawn at random each time the mode_cycles counter rolls over
            mode_cycles++;
            if (mode_cycles == 64) begin
                mode_cycles = 0;
                stall_mode  = t_rx_mode'($urandom_range(0, 3));
            end
            // one long hold so the pipe fills and blocks its input
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (!long_hold_done && results_checked >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    RX_OPEN:        rsp_if.ready <= 1'b1;
                    RX_COIN:        rsp_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:      rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_EVERY_THIRD: rsp_if.ready <= (mode_cycles % 3 != 0);
                    default:        rsp_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // run time limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d level beats outstanding",
                   cycle_count, expected_levels.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
